// ----- rtl/sbct_pkg.sv -----
// Shared constants and types for the swept box collision time block.
package sbct_pkg;

  localparam int SBCT_TIME_FRAC_BITS = 16;
  localparam int SBCT_COORD_W = 16;
  localparam int SBCT_MAG_W = 16;
  localparam int SBCT_LANES = 4;

  localparam int LANE_X_ENTRY = 0;
  localparam int LANE_X_EXIT = 1;
  localparam int LANE_Y_ENTRY = 2;
  localparam int LANE_Y_EXIT = 3;

  localparam logic signed [1:0] NORM_NEG = 2'sb11;
  localparam logic signed [1:0] NORM_ZERO = 2'sb00;
  localparam logic signed [1:0] NORM_POS = 2'sb01;

  typedef struct packed {
    logic reject;
    logic dx_zero;
    logic dy_zero;
    logic dx_pos;
    logic dy_pos;
  } sbct_side_t;

endpackage

// ----- rtl/sbct_front.sv -----
// Broad-phase test, zero-move rejection and divider operand setup.
module sbct_front (
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0]               moving_left,
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0]               moving_top,
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0]               moving_right,
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0]               moving_bottom,
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0]               fixed_left,
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0]               fixed_top,
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0]               fixed_right,
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0]               fixed_bottom,
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0]               move_x,
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0]               move_y,
  output sbct_pkg::sbct_side_t                                   side,
  output logic [sbct_pkg::SBCT_LANES-1:0][sbct_pkg::SBCT_MAG_W-1:0] a,
  output logic [sbct_pkg::SBCT_LANES-1:0][sbct_pkg::SBCT_MAG_W-1:0] b,
  output logic [sbct_pkg::SBCT_LANES-1:0]                        neg
);
  import sbct_pkg::*;

  logic signed [16:0] ml, mt, mr, mb, sl, st, sr, sb, dx, dy;
  logic signed [16:0] bl, bt, br, bb;
  logic signed [16:0] d_sl_mr, d_sr_ml, d_st_mb, d_sb_mt;
  logic signed [16:0] num [SBCT_LANES];
  logic signed [16:0] den [SBCT_LANES];
  logic signed [16:0] num_abs [SBCT_LANES];
  logic signed [16:0] den_abs [SBCT_LANES];
  logic dx_pos, dy_pos, dx_zero, dy_zero;

  always_comb begin
    ml = {moving_left[15], moving_left};
    mt = {moving_top[15], moving_top};
    mr = {moving_right[15], moving_right};
    mb = {moving_bottom[15], moving_bottom};
    sl = {fixed_left[15], fixed_left};
    st = {fixed_top[15], fixed_top};
    sr = {fixed_right[15], fixed_right};
    sb = {fixed_bottom[15], fixed_bottom};
    dx = {move_x[15], move_x};
    dy = {move_y[15], move_y};
    dx_pos = dx > 17'sd0;
    dy_pos = dy > 17'sd0;
    dx_zero = dx == 17'sd0;
    dy_zero = dy == 17'sd0;
    bl = dx_pos ? ml : ml + dx;
    bt = dy_pos ? mt : mt + dy;
    br = dx_pos ? mr + dx : mr;
    bb = dy_pos ? mb + dy : mb;
    side.reject = (br < sl) || (bl > sr) || (bb < st) || (bt > sb) || (dx_zero && dy_zero);
    side.dx_zero = dx_zero;
    side.dy_zero = dy_zero;
    side.dx_pos = dx_pos;
    side.dy_pos = dy_pos;
    d_sl_mr = sl - mr;
    d_sr_ml = sr - ml;
    d_st_mb = st - mb;
    d_sb_mt = sb - mt;
    num[LANE_X_ENTRY] = dx_pos ? d_sl_mr : d_sr_ml;
    num[LANE_X_EXIT] = dx_pos ? d_sr_ml : d_sl_mr;
    num[LANE_Y_ENTRY] = dy_pos ? d_st_mb : d_sb_mt;
    num[LANE_Y_EXIT] = dy_pos ? d_sb_mt : d_st_mb;
    den[LANE_X_ENTRY] = dx;
    den[LANE_X_EXIT] = dx;
    den[LANE_Y_ENTRY] = dy;
    den[LANE_Y_EXIT] = dy;
    for (int l = 0; l < SBCT_LANES; l++) begin
      num_abs[l] = num[l][16] ? -num[l] : num[l];
      den_abs[l] = den[l][16] ? -den[l] : den[l];
      a[l] = num_abs[l][SBCT_MAG_W-1:0];
      b[l] = den_abs[l][SBCT_MAG_W-1:0];
      neg[l] = num[l][16] != den[l][16];
    end
  end

endmodule

// ----- rtl/sbct_cell.sv -----
// One restoring-division step for all four time lanes, one quotient bit per cell.
module sbct_cell #(
  parameter int QW = 32
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   en,
  input  logic                                                   src_valid,
  input  sbct_pkg::sbct_side_t                                   src_side,
  input  logic [sbct_pkg::SBCT_LANES-1:0][sbct_pkg::SBCT_MAG_W-1:0] src_a,
  input  logic [sbct_pkg::SBCT_LANES-1:0][sbct_pkg::SBCT_MAG_W-1:0] src_b,
  input  logic [sbct_pkg::SBCT_LANES-1:0][sbct_pkg::SBCT_MAG_W-1:0] src_rem,
  input  logic [sbct_pkg::SBCT_LANES-1:0][QW-1:0]                src_q,
  input  logic [sbct_pkg::SBCT_LANES-1:0]                        src_neg,
  output logic                                                   valid,
  output sbct_pkg::sbct_side_t                                   side,
  output logic [sbct_pkg::SBCT_LANES-1:0][sbct_pkg::SBCT_MAG_W-1:0] a,
  output logic [sbct_pkg::SBCT_LANES-1:0][sbct_pkg::SBCT_MAG_W-1:0] b,
  output logic [sbct_pkg::SBCT_LANES-1:0][sbct_pkg::SBCT_MAG_W-1:0] rem,
  output logic [sbct_pkg::SBCT_LANES-1:0][QW-1:0]                q,
  output logic [sbct_pkg::SBCT_LANES-1:0]                        neg
);
  import sbct_pkg::*;

  logic [SBCT_LANES-1:0][SBCT_MAG_W:0]   trial;
  logic [SBCT_LANES-1:0][SBCT_MAG_W:0]   diff;
  logic [SBCT_LANES-1:0]                 fits;
  logic [SBCT_LANES-1:0][SBCT_MAG_W-1:0] rem_next;

  always_comb begin
    for (int l = 0; l < SBCT_LANES; l++) begin
      trial[l] = {src_rem[l], src_a[l][SBCT_MAG_W-1]};
      diff[l] = trial[l] - {1'b0, src_b[l]};
      fits[l] = trial[l] >= {1'b0, src_b[l]};
      rem_next[l] = fits[l] ? diff[l][SBCT_MAG_W-1:0] : trial[l][SBCT_MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= src_valid;
    end
    if (en) begin
      side <= src_side;
      neg <= src_neg;
      b <= src_b;
      rem <= rem_next;
      for (int l = 0; l < SBCT_LANES; l++) begin
        a[l] <= {src_a[l][SBCT_MAG_W-2:0], 1'b0};
        q[l] <= {src_q[l][QW-2:0], fits[l]};
      end
    end
  end

endmodule

// ----- rtl/sbct_back.sv -----
// Signed time recovery, interval tests and face normal selection.
module sbct_back #(
  parameter int TFB = 16,
  parameter int QW = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    src_valid,
  input  sbct_pkg::sbct_side_t                    src_side,
  input  logic [sbct_pkg::SBCT_LANES-1:0][sbct_pkg::SBCT_MAG_W-1:0] src_rem,
  input  logic [sbct_pkg::SBCT_LANES-1:0][QW-1:0] src_q,
  input  logic [sbct_pkg::SBCT_LANES-1:0]         src_neg,
  output logic                                    valid,
  output logic                                    hit,
  output logic [TFB:0]                            entry_time,
  output logic signed [1:0]                       normal_x,
  output logic signed [1:0]                       normal_y
);
  import sbct_pkg::*;

  localparam int TW = QW + 2;
  localparam logic signed [TW-1:0] T_MIN = {1'b1, {(TW-1){1'b0}}};
  localparam logic signed [TW-1:0] T_MAX = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0] T_ONE = TW'(1) << TFB;

  logic [SBCT_LANES-1:0][TW-1:0] mag;
  logic signed [TW-1:0] t_next [SBCT_LANES];
  logic signed [TW-1:0] t [SBCT_LANES];
  sbct_side_t side1;
  logic valid1;
  logic signed [TW-1:0] te, tx;
  logic x_wins, ok;

  always_comb begin
    for (int l = 0; l < SBCT_LANES; l++) begin
      mag[l] = {2'b00, src_q[l]} + TW'(src_rem[l] != '0);
      t_next[l] = src_neg[l] ? -$signed(mag[l]) : $signed({2'b00, src_q[l]});
    end
    if (src_side.dx_zero) begin
      t_next[LANE_X_ENTRY] = T_MIN;
      t_next[LANE_X_EXIT] = T_MAX;
    end
    if (src_side.dy_zero) begin
      t_next[LANE_Y_ENTRY] = T_MIN;
      t_next[LANE_Y_EXIT] = T_MAX;
    end
  end

  always_comb begin
    x_wins = t[LANE_X_ENTRY] > t[LANE_Y_ENTRY];
    te = x_wins ? t[LANE_X_ENTRY] : t[LANE_Y_ENTRY];
    tx = (t[LANE_X_EXIT] < t[LANE_Y_EXIT]) ? t[LANE_X_EXIT] : t[LANE_Y_EXIT];
    ok = !side1.reject
      && !(t[LANE_X_ENTRY] < 0 && t[LANE_Y_ENTRY] < 0)
      && !(t[LANE_X_ENTRY] > T_ONE) && !(t[LANE_Y_ENTRY] > T_ONE)
      && !(te > tx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      valid1 <= src_valid;
      valid <= valid1;
    end
    if (en) begin
      side1 <= src_side;
      for (int l = 0; l < SBCT_LANES; l++) begin
        t[l] <= t_next[l];
      end
      hit <= ok;
      entry_time <= ok ? te[TFB:0] : '0;
      normal_x <= (ok && x_wins) ? (side1.dx_pos ? NORM_NEG : NORM_POS) : NORM_ZERO;
      normal_y <= (ok && !x_wins) ? (side1.dy_pos ? NORM_NEG : NORM_POS) : NORM_ZERO;
    end
  end

endmodule

// ----- rtl/swept_box_collision_time_top.sv -----
// Throughput: one request per cycle while in_stall is low; the divider is a chain of TIME_FRAC_BITS + 16 cells.
// Each cell resolves one quotient bit of all four axis times and passes them on.
// An output register and a one-entry skid register decouple the two handshakes.
// Reset clears all valid flags; the data path needs no clearing.
module swept_box_collision_time_top #(
  parameter int TIME_FRAC_BITS = sbct_pkg::SBCT_TIME_FRAC_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0] moving_left,
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0] moving_top,
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0] moving_right,
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0] moving_bottom,
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0] fixed_left,
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0] fixed_top,
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0] fixed_right,
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0] fixed_bottom,
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0] move_x,
  input  logic signed [sbct_pkg::SBCT_COORD_W-1:0] move_y,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic                                     hit,
  output logic [TIME_FRAC_BITS:0]                  entry_time,
  output logic signed [1:0]                        normal_x,
  output logic signed [1:0]                        normal_y
);
  import sbct_pkg::*;

  localparam int QW = SBCT_MAG_W + TIME_FRAC_BITS;

  logic en;
  logic                                  c_valid [QW+1];
  sbct_side_t                            c_side  [QW+1];
  logic [SBCT_LANES-1:0][SBCT_MAG_W-1:0] c_a     [QW+1];
  logic [SBCT_LANES-1:0][SBCT_MAG_W-1:0] c_b     [QW+1];
  logic [SBCT_LANES-1:0][SBCT_MAG_W-1:0] c_rem   [QW+1];
  logic [SBCT_LANES-1:0][QW-1:0]         c_q     [QW+1];
  logic [SBCT_LANES-1:0]                 c_neg   [QW+1];

  logic                    tail_valid;
  logic                    tail_hit;
  logic [TIME_FRAC_BITS:0] tail_time;
  logic signed [1:0]       tail_nx, tail_ny;

  logic                    skid_valid;
  logic                    skid_hit;
  logic [TIME_FRAC_BITS:0] skid_time;
  logic signed [1:0]       skid_nx, skid_ny;
  logic                    out_free;

  assign en = !skid_valid;
  assign in_stall = skid_valid;
  assign out_free = !out_valid || !out_stall;

  assign c_valid[0] = in_valid;
  assign c_rem[0] = '0;
  assign c_q[0] = '0;

  sbct_front u_front (
    .moving_left(moving_left), .moving_top(moving_top),
    .moving_right(moving_right), .moving_bottom(moving_bottom),
    .fixed_left(fixed_left), .fixed_top(fixed_top),
    .fixed_right(fixed_right), .fixed_bottom(fixed_bottom),
    .move_x(move_x), .move_y(move_y),
    .side(c_side[0]), .a(c_a[0]), .b(c_b[0]), .neg(c_neg[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    sbct_cell #(.QW(QW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .src_valid(c_valid[i]), .src_side(c_side[i]), .src_a(c_a[i]), .src_b(c_b[i]),
      .src_rem(c_rem[i]), .src_q(c_q[i]), .src_neg(c_neg[i]),
      .valid(c_valid[i+1]), .side(c_side[i+1]), .a(c_a[i+1]), .b(c_b[i+1]),
      .rem(c_rem[i+1]), .q(c_q[i+1]), .neg(c_neg[i+1])
    );
  end

  sbct_back #(.TFB(TIME_FRAC_BITS), .QW(QW)) u_back (
    .clk(clk), .rst(rst), .en(en),
    .src_valid(c_valid[QW]), .src_side(c_side[QW]), .src_rem(c_rem[QW]),
    .src_q(c_q[QW]), .src_neg(c_neg[QW]),
    .valid(tail_valid), .hit(tail_hit), .entry_time(tail_time),
    .normal_x(tail_nx), .normal_y(tail_ny)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (en) begin
      if (out_free) begin
        out_valid <= tail_valid;
      end else if (tail_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (out_free) begin
      out_valid <= 1'b1;
      skid_valid <= 1'b0;
    end
    if (en) begin
      if (out_free) begin
        hit <= tail_hit;
        entry_time <= tail_time;
        normal_x <= tail_nx;
        normal_y <= tail_ny;
      end else begin
        skid_hit <= tail_hit;
        skid_time <= tail_time;
        skid_nx <= tail_nx;
        skid_ny <= tail_ny;
      end
    end else if (out_free) begin
      hit <= skid_hit;
      entry_time <= skid_time;
      normal_x <= skid_nx;
      normal_y <= skid_ny;
    end
  end

endmodule
